@@ hdl/assert_macros.svh @@
// assertion macros included by tcw_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while dis is high
`define TCW_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, skipped while dis is high
`define TCW_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hdl/tcw_pkg.sv @@
// shared types and constants of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // control bytes
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_BS = 8'h08;

  localparam logic [7:0] BLANK_CHAR     = 8'h20;
  localparam logic [7:0] ATTR_RESET_VAL = 8'h07;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_READ,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep;
    logic read_cap;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic need_sweep;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

@@ hdl/tcw_if.sv @@
// valid/ready channels for command beats and result beats
`timescale 1ns / 1ps

interface tcw_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  character;
  logic [7:0]  fill_attribute;
  logic [10:0] cell_address;

  modport source (output valid, operation, character, fill_attribute, cell_address,
                  input ready);
  modport sink   (input valid, operation, character, fill_attribute, cell_address,
                  output ready);
endinterface

interface tcw_res_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_position;
  logic [7:0]  read_character;
  logic [7:0]  read_attribute;

  modport source (output valid, cursor_column, cursor_row, cursor_position,
                  read_character, read_attribute, input ready);
  modport sink   (input valid, cursor_column, cursor_row, cursor_position,
                  read_character, read_attribute, output ready);
endinterface

@@ hdl/tcw_ctrl.sv @@
// sequencing state machine of the text console writer
`timescale 1ns / 1ps

module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.is_read) state_next = ST_READ;
        else if (status.need_sweep) state_next = ST_SWEEP;
        else state_next = ST_DONE;
      end
      ST_SWEEP: begin
        if (status.sweep_last) state_next = ST_DONE;
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_EXEC:  cmd.exec = 1'b1;
      ST_SWEEP: cmd.sweep = 1'b1;
      ST_READ:  cmd.read_cap = 1'b1;
      ST_DONE:  cmd.load_out = status.out_free;
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/tcw_dp.sv @@
// cursor, cell memory, sweep counter and result register
`timescale 1ns / 1ps

module tcw_dp
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic [1:0]  operation,
  input  logic [7:0]  character,
  input  logic [7:0]  fill_attribute,
  input  logic [10:0] cell_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  cursor_column,
  output logic [4:0]  cursor_row,
  output logic [10:0] cursor_position,
  output logic [7:0]  read_character,
  output logic [7:0]  read_attribute
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LIMIT      = (ROWS - 1) * COLUMNS;
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int SW         = $clog2(CELL_COUNT + 1);
  localparam int XW         = (AW > 11) ? AW : 11;

  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [AW-1:0] POS_COLS  = AW'(COLUMNS);
  localparam logic [AW-1:0] POS_LIMIT = AW'(LIMIT);
  localparam logic [SW-1:0] S_LIMIT   = SW'(LIMIT);
  localparam logic [SW-1:0] S_END     = SW'(CELL_COUNT);
  localparam logic [XW-1:0] X_COUNT   = XW'(CELL_COUNT);

  logic [7:0]  text_attribute;

  // latched command beat
  logic [1:0]  op_q;
  logic [7:0]  ch_q;
  logic [7:0]  fill_q;
  logic [10:0] addr_q;

  // cursor
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] pos;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [AW-1:0] pos_next;
  logic          scroll;
  logic          char_wr;

  // cell memory
  logic [15:0] mem [CELL_COUNT];
  logic [15:0] rdata;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0] wr_data;

  // sweep state
  logic [SW-1:0] s;
  logic [AW-1:0] w_addr;
  logic          wr_pending;
  logic          blank_d;
  logic          sweep_clear;

  // read hold
  logic [XW-1:0] addr_x;
  logic          addr_ok;
  logic          rd_ok;
  logic [15:0]   rd_hold;

  logic [31:0] col_w;
  logic [31:0] row_w;
  logic [31:0] pos_w;

  assign addr_x  = XW'(addr_q);
  assign addr_ok = addr_x < X_COUNT;

  // text attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET_VAL;
    end else if (cfg_write) begin
      text_attribute <= cfg_data;
    end
  end

  // capture command beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= operation;
      ch_q   <= character;
      fill_q <= fill_attribute;
      addr_q <= cell_address;
    end
  end

  // cursor update for one byte or a clear
  always_comb begin
    col_next = col;
    row_next = row;
    pos_next = pos;
    scroll   = 1'b0;
    char_wr  = 1'b0;
    unique case (op_q)
      OP_WRITE: begin
        priority if (ch_q == CH_CR) begin
          col_next = '0;
          pos_next = pos - AW'(col);
        end else if (ch_q == CH_LF) begin
          if (row == ROW_LAST) begin
            scroll = 1'b1;
          end else begin
            row_next = row + RW'(1);
            pos_next = pos + POS_COLS;
          end
        end else if (ch_q == CH_BS) begin
          if (col != '0) begin
            col_next = col - CW'(1);
            pos_next = pos - AW'(1);
          end
        end else begin
          char_wr = 1'b1;
          if (col == COL_LAST) begin
            col_next = '0;
            if (row == ROW_LAST) begin
              scroll   = 1'b1;
              pos_next = POS_LIMIT;
            end else begin
              row_next = row + RW'(1);
              pos_next = pos + AW'(1);
            end
          end else begin
            col_next = col + CW'(1);
            pos_next = pos + AW'(1);
          end
        end
      end
      OP_CLEAR: begin
        col_next = '0;
        row_next = '0;
        pos_next = '0;
      end
      default: begin
      end
    endcase
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      pos <= '0;
    end else if (cmd.exec) begin
      col <= col_next;
      row <= row_next;
      pos <= pos_next;
    end
  end

  assign status.is_read    = (op_q == OP_READ);
  assign status.need_sweep = (op_q == OP_CLEAR) || scroll;
  assign status.sweep_last = (s == S_END);
  assign status.out_free   = !out_valid || out_ready;

  // sweep counter and delayed write slot
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pending <= 1'b0;
    end else if (cmd.exec) begin
      wr_pending <= 1'b0;
    end else if (cmd.sweep) begin
      wr_pending <= (s < S_END);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      s           <= '0;
      sweep_clear <= (op_q == OP_CLEAR);
    end else if (cmd.sweep) begin
      if (s < S_END) s <= s + SW'(1);
      w_addr  <= AW'(s);
      blank_d <= !(s < S_LIMIT);
    end
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.exec && (op_q == OP_READ) && addr_ok) begin
      rd_en   = 1'b1;
      rd_addr = addr_x[AW-1:0];
    end else if (cmd.sweep && (s < S_LIMIT)) begin
      rd_en   = 1'b1;
      rd_addr = AW'(s) + POS_COLS;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = w_addr;
    wr_data = {text_attribute, BLANK_CHAR};
    priority if (cmd.exec && char_wr) begin
      wr_en   = 1'b1;
      wr_addr = pos;
      wr_data = {text_attribute, ch_q};
    end else if (wr_pending) begin
      wr_en = 1'b1;
      if (sweep_clear) wr_data = {fill_q, ch_q};
      else if (!blank_d) wr_data = rdata;
    end else begin
      wr_en = 1'b0;
    end
  end

  // cell memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[rd_addr];
  end

  // read result hold
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_ok   <= addr_ok;
      rd_hold <= '0;
    end else if (cmd.read_cap && rd_ok) begin
      rd_hold <= rdata;
    end
  end

  assign col_w = 32'(col);
  assign row_w = 32'(row);
  assign pos_w = 32'(pos);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cursor_column   <= col_w[6:0];
      cursor_row      <= row_w[4:0];
      cursor_position <= pos_w[10:0];
      read_character  <= rd_hold[7:0];
      read_attribute  <= rd_hold[15:8];
    end
  end

endmodule

@@ hdl/text_console_writer.sv @@
// Text console writer top level: 80x25 cell grid with write cursor.
// A command beat passes the exec state, then the read state for a read or the sweep
// state for a clear or scroll, and ends in done, which loads the result register.
// Input is held off until that load; a clear or scroll sweeps
// the cell memory (one read and one write port) one cell per cycle with input held off.
// Reset (synchronous, active high): cursor at home, attribute 0x07, cells undefined.
`timescale 1ns / 1ps

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  tcw_cmd_if.sink    cmd_in,
  tcw_res_if.source  res_out
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd_in.valid),
    .in_ready (cmd_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .operation       (cmd_in.operation),
    .character       (cmd_in.character),
    .fill_attribute  (cmd_in.fill_attribute),
    .cell_address    (cmd_in.cell_address),
    .out_valid       (res_out.valid),
    .out_ready       (res_out.ready),
    .cursor_column   (res_out.cursor_column),
    .cursor_row      (res_out.cursor_row),
    .cursor_position (res_out.cursor_position),
    .read_character  (res_out.read_character),
    .read_attribute  (res_out.read_attribute)
  );

endmodule

@@ hdl/tcw_checker.sv @@
// port-level checks of the text console writer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  cursor_column,
  input logic [4:0]  cursor_row,
  input logic [10:0] cursor_position
);

  logic cursor_ok;

  // reported cursor stays on the grid
  assign cursor_ok = (32'(cursor_column) < COLUMNS) && (32'(cursor_row) < ROWS);

  // a stalled result beat holds
  `TCW_ASSERT_NEXT(a_res_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(cursor_position))

  // one command beat at a time: input closes right after a beat
  `TCW_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)

  // result cursor on the grid
  `TCW_ASSERT_NOW(a_cursor_range, clk, rst, out_valid, cursor_ok)

  // reset empties the result register
  `TCW_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (cmd_in.valid),
  .in_ready        (cmd_in.ready),
  .out_valid       (res_out.valid),
  .out_ready       (res_out.ready),
  .cursor_column   (res_out.cursor_column),
  .cursor_row      (res_out.cursor_row),
  .cursor_position (res_out.cursor_position)
);

@@ test/testbench.sv @@
// self-checking testbench for the text console writer: random traffic against a cycle-free predictor
`timescale 1ns / 1ps

module testbench
  import tcw_pkg::*;
();

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int SWEEP_CYCLES = CELLS + 10;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int IDLE_PCT = 23;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int HOLD_OFF_AFTER = 100;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  character;
    logic [7:0]  fill_attribute;
    logic [10:0] cell_address;
  } console_cmd_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_position;
    logic [7:0]  read_character;
    logic [7:0]  read_attribute;
  } console_report_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_write = 1'b0;
  logic [7:0]   cfg_data = '0;
  logic         drv_valid = 1'b0;
  console_cmd_t drv_cmd = '0;
  logic         rcv_ready = 1'b0;
  logic         no_idle = 1'b0;
  logic         cmd_beat = 1'b0;

  // screen model and cursor
  logic [15:0] cell_model [CELLS];
  int          cur_col = 0;
  int          cur_row = 0;
  logic [7:0]  attr_model = ATTR_RESET_VAL;
  int          scroll_count = 0;
  int          clear_count = 0;
  int          read_count = 0;

  console_cmd_t    pending_cmds[$];
  console_report_t expected_reports[$];
  int error_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  tcw_cmd_if cmd_ch();
  tcw_res_if res_ch();

  assign cmd_ch.valid          = drv_valid;
  assign cmd_ch.operation      = drv_cmd.operation;
  assign cmd_ch.character      = drv_cmd.character;
  assign cmd_ch.fill_attribute = drv_cmd.fill_attribute;
  assign cmd_ch.cell_address   = drv_cmd.cell_address;
  assign res_ch.ready          = rcv_ready;

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_in    (cmd_ch),
    .res_out   (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // apply one command to the screen model and return the cursor report
  function automatic console_report_t console_step(console_cmd_t c);
    console_report_t r;
    int pos;
    r = '0;
    if (c.operation == OP_WRITE) begin
      if (c.character == CH_CR) begin
        cur_col = 0;
      end else if (c.character == CH_LF) begin
        cur_row++;
      end else if (c.character == CH_BS) begin
        if (cur_col > 0) cur_col--;
      end else begin
        cell_model[cur_row * COLUMNS + cur_col] = {attr_model, c.character};
        cur_col++;
      end
      if (cur_col > COLUMNS - 1) begin
        cur_col = 0;
        cur_row++;
      end
      // scroll up: each row takes the one below, bottom row goes blank
      if (cur_row > ROWS - 1) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) cell_model[i] = cell_model[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) cell_model[i] = {attr_model, BLANK_CHAR};
        cur_row = ROWS - 1;
        scroll_count++;
      end
    end else if (c.operation == OP_CLEAR) begin
      for (int i = 0; i < CELLS; i++) cell_model[i] = {c.fill_attribute, c.character};
      cur_col = 0;
      cur_row = 0;
      clear_count++;
    end else if (c.operation == OP_READ) begin
      read_count++;
      if (c.cell_address < CELLS) begin
        r.read_character = cell_model[c.cell_address][7:0];
        r.read_attribute = cell_model[c.cell_address][15:8];
      end
    end
    pos = cur_row * COLUMNS + cur_col;
    r.cursor_column   = cur_col[6:0];
    r.cursor_row      = cur_row[4:0];
    r.cursor_position = pos[10:0];
    return r;
  endfunction

  function automatic console_cmd_t random_cmd(logic [1:0] op);
    console_cmd_t c;
    c.operation      = op;
    c.character      = 8'($urandom_range(0, 255));
    c.fill_attribute = 8'($urandom_range(0, 255));
    c.cell_address   = 11'($urandom_range(0, 2047));
    return c;
  endfunction

  task automatic queue_cmd(logic [1:0] op, logic [7:0] ch, logic [7:0] fill, logic [10:0] addr);
    pending_cmds.push_back('{op, ch, fill, addr});
  endtask

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // mixed traffic: text lines ending in CR/LF, read bursts, controls, clears
  task automatic queue_random(int count);
    int added, pick, len;
    logic [7:0] glyph;
    console_cmd_t c;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20) : $urandom_range(40, 100);
        repeat (len) begin
          do glyph = 8'($urandom_range(0, 255));
          while (glyph == CH_CR || glyph == CH_LF || glyph == CH_BS);
          c = random_cmd(OP_WRITE);
          c.character = glyph;
          pending_cmds.push_back(c);
        end
        c = random_cmd(OP_WRITE);
        c.character = CH_CR;
        pending_cmds.push_back(c);
        added += len + 1;
        if ($urandom_range(0, 4) != 0) begin
          c.character = CH_LF;
          pending_cmds.push_back(c);
          added++;
        end
      end else if (pick < 70) begin
        len = $urandom_range(1, 8);
        repeat (len) pending_cmds.push_back(random_cmd(OP_READ));
        added += len;
      end else if (pick < 80) begin
        pending_cmds.push_back(random_cmd(OP_WRITE));
        added++;
      end else if (pick < 95) begin
        glyph = (pick < 90) ? CH_LF : CH_BS;
        len = $urandom_range(1, 8);
        repeat (len) begin
          c = random_cmd(OP_WRITE);
          c.character = glyph;
          pending_cmds.push_back(c);
        end
        added += len;
      end else if (pick < 98) begin
        pending_cmds.push_back(random_cmd(OP_CLEAR));
        added++;
      end else begin
        pending_cmds.push_back(random_cmd(OP_NONE));
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || drv_valid || expected_reports.size() != 0);
  endtask

  task automatic set_attribute(logic [7:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    attr_model = value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // command driver
  always @(negedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || cmd_beat) begin
      if (pending_cmds.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
        drv_cmd <= pending_cmds.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off early in the run
  always @(negedge clk) begin
    if (rst) begin
      rcv_ready <= 1'b0;
    end else if (hold_left > 0) begin
      rcv_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_OFF_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
      rcv_ready <= 1'b0;
    end else begin
      rcv_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // beat monitor: predict on command beats, compare on result beats
  always @(posedge clk) begin
    console_report_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("FAILURE");
      $finish;
    end
    cmd_beat <= !rst && drv_valid && cmd_ch.ready;
    if (!rst && drv_valid && cmd_ch.ready)
      expected_reports.push_back(console_step(drv_cmd));
    if (!rst && res_ch.valid && rcv_ready) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        error_count++;
        $display("%0t: result beat with nothing expected: column %0d row %0d", $time,
                 res_ch.cursor_column, res_ch.cursor_row);
      end else begin
        want = expected_reports.pop_front();
        check_field("cursor_column", want.cursor_column, res_ch.cursor_column);
        check_field("cursor_row", want.cursor_row, res_ch.cursor_row);
        check_field("cursor_position", want.cursor_position, res_ch.cursor_position);
        check_field("read_character", want.read_character, res_ch.read_character);
        check_field("read_attribute", want.read_attribute, res_ch.read_attribute);
      end
    end
  end

  // stimulus phases, one text attribute setting each
  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: defined screen first, then extremes and corner cases
    queue_cmd(OP_CLEAR, BLANK_CHAR, ATTR_RESET_VAL, 11'd0);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd0);
    queue_cmd(OP_WRITE, 8'h00, 8'hff, 11'h7ff);
    queue_cmd(OP_WRITE, 8'hff, 8'h00, 11'd0);
    queue_cmd(OP_READ, 8'hff, 8'hff, 11'd0);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd1);
    queue_cmd(OP_WRITE, CH_BS, 8'h00, 11'd0);
    queue_cmd(OP_WRITE, CH_BS, 8'h00, 11'd0);
    queue_cmd(OP_WRITE, CH_BS, 8'h00, 11'd0);
    queue_cmd(OP_WRITE, 8'h41, 8'h00, 11'd0);
    queue_cmd(OP_WRITE, CH_CR, 8'h00, 11'd0);
    queue_cmd(OP_WRITE, CH_LF, 8'h00, 11'd0);
    queue_cmd(OP_WRITE, 8'h7f, 8'h00, 11'd0);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd80);
    queue_cmd(OP_CLEAR, 8'hff, 8'hff, 11'h7ff);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd1999);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd2000);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd2047);
    queue_cmd(OP_NONE, 8'hff, 8'hff, 11'd1000);
    queue_cmd(OP_CLEAR, 8'h00, 8'h00, 11'd0);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd1024);
    queue_cmd(OP_CLEAR, BLANK_CHAR, ATTR_RESET_VAL, 11'd0);
    queue_random(240);
    wait_drained();

    set_attribute(8'h00);
    queue_random(180);
    wait_drained();

    set_attribute(8'hff);
    queue_random(180);
    wait_drained();

    // back-to-back stretch, no idling on either side
    no_idle <= 1'b1;
    set_attribute(8'($urandom_range(1, 254)));
    queue_random(180);
    wait_drained();
    no_idle <= 1'b0;

    set_attribute(8'($urandom_range(0, 255)));
    queue_random(170);
    wait_drained();
    repeat (SWEEP_CYCLES) @(negedge clk);

    $display("checked %0d results: %0d reads, %0d clears, %0d scrolls", results_seen,
             read_count, clear_count, scroll_count);
    $display("text attribute at reset, 0x00, 0xff and two random values; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ text_console_writer.f @@
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_if.sv
hdl/tcw_ctrl.sv
hdl/tcw_dp.sv
hdl/text_console_writer.sv
hdl/tcw_checker.sv
test/testbench.sv
